/* sv/rsnh_pkg.sv */
`default_nettype none

package rsnh_pkg;

  localparam int unsigned N_LANES    = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  // Radicand of both square roots: dot^2 - gamma*2^16 and sum of v^2
  localparam int unsigned RAD_W      = 102;
  localparam int unsigned ROOT_W     = RAD_W / 2;
  localparam int unsigned VMAG_W     = 50;
  // |v| <= len, so |v|*2^16/len never exceeds 2^16
  localparam int unsigned QUO_W      = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTRE_X   = 3'd0,
    CFG_CENTRE_Y   = 3'd1,
    CFG_CENTRE_Z   = 3'd2,
    CFG_RADIUS     = 3'd3,
    CFG_SURFACE_ID = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic        [47:0] best_dist_sq;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic        [47:0] new_best_dist_sq;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic        [3:0]  hit_surface;
  } out_t;

  typedef struct packed {
    logic                      miss;
    logic [47:0]               best;
    logic signed [50:0]        dot;
    logic [N_LANES-1:0][32:0]  oc;
    logic [N_LANES-1:0][31:0]  e;
    logic [N_LANES-1:0][31:0]  d;
  } sq1_pay_t;

  typedef struct packed {
    logic                           miss;
    logic [47:0]                    best;
    logic [47:0]                    t2;
    logic [N_LANES-1:0][31:0]       pt;
    logic [N_LANES-1:0]             vneg;
    logic [N_LANES-1:0][VMAG_W-1:0] vm;
  } sq2_pay_t;

  typedef struct packed {
    logic                     miss;
    logic [47:0]              best;
    logic [47:0]              t2;
    logic [N_LANES-1:0][31:0] pt;
    logic [N_LANES-1:0]       vneg;
    logic                     lz;
  } div_pay_t;

endpackage

`default_nettype wire

/* sv/rsnh_sqrt.sv */
`default_nettype none

module rsnh_sqrt #(
  parameter int unsigned RadW = rsnh_pkg::RAD_W,
  parameter int unsigned PayW = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                vld_i,
  input  logic [RadW-1:0]     rad_i,
  input  logic [PayW-1:0]     pay_i,
  output logic                vld_o,
  output logic [RadW/2-1:0]   root_o,
  output logic [PayW-1:0]     pay_o
);

  localparam int unsigned RootW = RadW / 2;
  localparam int unsigned RemW  = RootW + 2;

  logic             vld_q  [RootW];
  logic [RemW-1:0]  rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];
  logic [RadW-1:0]  rad_q  [RootW];
  logic [PayW-1:0]  pay_q  [RootW];

  logic             cur_vld  [RootW];
  logic [RemW-1:0]  cur_rem  [RootW];
  logic [RootW-1:0] cur_root [RootW];
  logic [RadW-1:0]  cur_rad  [RootW];
  logic [PayW-1:0]  cur_pay  [RootW];

  logic [RemW+1:0]  cat   [RootW];
  logic [RemW+1:0]  trial [RootW];
  logic             ge    [RootW];

  // One result bit per stage, two radicand bits consumed, top bits first
  always_comb begin
    cur_vld[0]  = vld_i;
    cur_rem[0]  = '0;
    cur_root[0] = '0;
    cur_rad[0]  = rad_i;
    cur_pay[0]  = pay_i;
    for (int k = 1; k < RootW; k++) begin
      cur_vld[k]  = vld_q[k-1];
      cur_rem[k]  = rem_q[k-1];
      cur_root[k] = root_q[k-1];
      cur_rad[k]  = rad_q[k-1];
      cur_pay[k]  = pay_q[k-1];
    end
    for (int k = 0; k < RootW; k++) begin
      cat[k]   = {cur_rem[k], cur_rad[k][RadW-1-2*k -: 2]};
      trial[k] = {2'b00, cur_root[k], 2'b01};
      ge[k]    = cat[k] >= trial[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < RootW; k++) vld_q[k] <= 1'b0;
    end else if (adv_i) begin
      for (int k = 0; k < RootW; k++) vld_q[k] <= cur_vld[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < RootW; k++) begin
        rem_q[k]  <= ge[k] ? RemW'(cat[k] - trial[k]) : RemW'(cat[k]);
        root_q[k] <= {cur_root[k][RootW-2:0], ge[k]};
        rad_q[k]  <= cur_rad[k];
        pay_q[k]  <= cur_pay[k];
      end
    end
  end

  assign vld_o  = vld_q[RootW-1];
  assign root_o = root_q[RootW-1];
  assign pay_o  = pay_q[RootW-1];

endmodule

`default_nettype wire

/* sv/rsnh_div.sv */
`default_nettype none

module rsnh_div #(
  parameter int unsigned MagW = rsnh_pkg::VMAG_W,
  parameter int unsigned DenW = rsnh_pkg::ROOT_W,
  parameter int unsigned QuoW = rsnh_pkg::QUO_W,
  parameter int unsigned PayW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            vld_i,
  input  logic [MagW-1:0] mag_i [rsnh_pkg::N_LANES],
  input  logic [DenW-1:0] den_i,
  input  logic [PayW-1:0] pay_i,
  output logic            vld_o,
  output logic [QuoW-1:0] quo_o [rsnh_pkg::N_LANES],
  output logic [PayW-1:0] pay_o
);

  localparam int unsigned NL   = rsnh_pkg::N_LANES;
  localparam int unsigned RemW = DenW + QuoW - 1;

  logic            vld_q [QuoW];
  logic [RemW-1:0] rem_q [QuoW][NL];
  logic [QuoW-1:0] quo_q [QuoW][NL];
  logic [DenW-1:0] den_q [QuoW];
  logic [PayW-1:0] pay_q [QuoW];

  logic            cur_vld [QuoW];
  logic [RemW-1:0] cur_rem [QuoW][NL];
  logic [QuoW-1:0] cur_quo [QuoW][NL];
  logic [DenW-1:0] cur_den [QuoW];
  logic [PayW-1:0] cur_pay [QuoW];

  logic [RemW-1:0] dsh [QuoW];
  logic            ge  [QuoW][NL];

  // Restoring division of mag*2^16 by den, one quotient bit per stage
  always_comb begin
    cur_vld[0] = vld_i;
    cur_den[0] = den_i;
    cur_pay[0] = pay_i;
    for (int l = 0; l < NL; l++) begin
      cur_rem[0][l] = RemW'(mag_i[l]) << (QuoW - 1);
      cur_quo[0][l] = '0;
    end
    for (int k = 1; k < QuoW; k++) begin
      cur_vld[k] = vld_q[k-1];
      cur_den[k] = den_q[k-1];
      cur_pay[k] = pay_q[k-1];
      for (int l = 0; l < NL; l++) begin
        cur_rem[k][l] = rem_q[k-1][l];
        cur_quo[k][l] = quo_q[k-1][l];
      end
    end
    for (int k = 0; k < QuoW; k++) begin
      dsh[k] = RemW'(cur_den[k]) << (QuoW - 1 - k);
      for (int l = 0; l < NL; l++) ge[k][l] = cur_rem[k][l] >= dsh[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < QuoW; k++) vld_q[k] <= 1'b0;
    end else if (adv_i) begin
      for (int k = 0; k < QuoW; k++) vld_q[k] <= cur_vld[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < QuoW; k++) begin
        den_q[k] <= cur_den[k];
        pay_q[k] <= cur_pay[k];
        for (int l = 0; l < NL; l++) begin
          rem_q[k][l] <= ge[k][l] ? cur_rem[k][l] - dsh[k] : cur_rem[k][l];
          quo_q[k][l] <= {cur_quo[k][l][QuoW-2:0], ge[k][l]};
        end
      end
    end
  end

  assign vld_o = vld_q[QuoW-1];
  assign pay_o = pay_q[QuoW-1];
  always_comb begin
    for (int l = 0; l < NL; l++) quo_o[l] = quo_q[QuoW-1][l];
  end

endmodule

`default_nettype wire

/* sv/ray_sphere_nearest_hit.sv */
// The pipeline has 130 register stages: 5 setup stages, 51-stage discriminant root, 5 hit-point
// stages, 51-stage normal-length root, 17-stage divider, output register. Throughput: one
// ray per cycle; every stage advances together and the whole pipeline holds while the
// output waits to be taken.
// Reset clears the stage valid bits and loads the sphere registers with centre 0,
// radius 1.0 and surface 0.
`default_nettype none

module ray_sphere_nearest_hit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  rsnh_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output rsnh_pkg::out_t                      out_data_o,
  input  logic                                cfg_we_i,
  input  logic [rsnh_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rsnh_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned NL    = rsnh_pkg::N_LANES;
  localparam int unsigned RootW = rsnh_pkg::ROOT_W;
  localparam int unsigned RadW  = rsnh_pkg::RAD_W;
  localparam int unsigned VmW   = rsnh_pkg::VMAG_W;
  localparam int unsigned QuoW  = rsnh_pkg::QUO_W;

  // ---------------------------------------------------------------- config
  logic signed [31:0] centre_x_q, centre_y_q, centre_z_q;
  logic        [30:0] radius_q;
  logic        [3:0]  surf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_x_q <= '0;
      centre_y_q <= '0;
      centre_z_q <= '0;
      radius_q   <= 31'd65536;
      surf_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (rsnh_pkg::cfg_reg_e'(cfg_idx_i))
        rsnh_pkg::CFG_CENTRE_X:   centre_x_q <= cfg_data_i;
        rsnh_pkg::CFG_CENTRE_Y:   centre_y_q <= cfg_data_i;
        rsnh_pkg::CFG_CENTRE_Z:   centre_z_q <= cfg_data_i;
        rsnh_pkg::CFG_RADIUS:     radius_q   <= cfg_data_i[30:0];
        rsnh_pkg::CFG_SURFACE_ID: surf_q     <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  logic           adv;
  logic           out_vld_q;
  rsnh_pkg::out_t out_q;

  // Advance all stages unless the output holds an untaken result
  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  // ---------------------------------------------------------------- S1: oc = e - c
  logic signed [31:0] e_in [NL];
  logic signed [31:0] d_in [NL];
  logic signed [31:0] ctr  [NL];
  logic signed [32:0] oc_d [NL];

  always_comb begin
    e_in[0] = in_data_i.origin_x;
    e_in[1] = in_data_i.origin_y;
    e_in[2] = in_data_i.origin_z;
    d_in[0] = in_data_i.dir_x;
    d_in[1] = in_data_i.dir_y;
    d_in[2] = in_data_i.dir_z;
    ctr[0]  = centre_x_q;
    ctr[1]  = centre_y_q;
    ctr[2]  = centre_z_q;
    for (int i = 0; i < NL; i++) oc_d[i] = 33'(e_in[i]) - 33'(ctr[i]);
  end

  logic               s1_vld_q;
  logic signed [31:0] s1_e_q  [NL];
  logic signed [31:0] s1_d_q  [NL];
  logic signed [32:0] s1_oc_q [NL];
  logic        [47:0] s1_best_q;

  // ---------------------------------------------------------------- S2: products
  logic        [32:0] ocm [NL];
  logic               s2_vld_q;
  logic signed [31:0] s2_e_q  [NL];
  logic signed [31:0] s2_d_q  [NL];
  logic signed [32:0] s2_oc_q [NL];
  logic        [47:0] s2_best_q;
  logic signed [64:0] s2_p_q  [NL];
  logic        [65:0] s2_q_q  [NL];
  logic        [61:0] s2_r2_q;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      ocm[i] = s1_oc_q[i][32] ? 33'(-s1_oc_q[i]) : 33'(s1_oc_q[i]);
    end
  end

  // ---------------------------------------------------------------- S3: dot, gamma
  logic signed [50:0] dot_c;
  logic        [50:0] sq_c;
  logic signed [51:0] gam_c;
  logic               s3_vld_q;
  logic signed [31:0] s3_e_q  [NL];
  logic signed [31:0] s3_d_q  [NL];
  logic signed [32:0] s3_oc_q [NL];
  logic        [47:0] s3_best_q;
  logic signed [50:0] s3_dot_q;
  logic signed [51:0] s3_gam_q;

  always_comb begin
    dot_c = 51'(s2_p_q[0] >>> 16) + 51'(s2_p_q[1] >>> 16) + 51'(s2_p_q[2] >>> 16);
    sq_c  = 51'(s2_q_q[0] >> 16) + 51'(s2_q_q[1] >> 16) + 51'(s2_q_q[2] >> 16);
    gam_c = $signed({1'b0, sq_c}) - $signed({6'b0, s2_r2_q[61:16]});
  end

  // ---------------------------------------------------------------- S4: dot^2 partials
  logic        [49:0] dm;
  logic               s4_vld_q;
  logic signed [31:0] s4_e_q  [NL];
  logic signed [31:0] s4_d_q  [NL];
  logic signed [32:0] s4_oc_q [NL];
  logic        [47:0] s4_best_q;
  logic signed [50:0] s4_dot_q;
  logic signed [51:0] s4_gam_q;
  logic        [49:0] s4_hh_q, s4_hl_q, s4_ll_q;

  assign dm = s3_dot_q[50] ? 50'(-s3_dot_q) : 50'(s3_dot_q);

  // ---------------------------------------------------------------- S5: dot^2
  logic               s5_vld_q;
  logic signed [31:0] s5_e_q  [NL];
  logic signed [31:0] s5_d_q  [NL];
  logic signed [32:0] s5_oc_q [NL];
  logic        [47:0] s5_best_q;
  logic signed [50:0] s5_dot_q;
  logic signed [51:0] s5_gam_q;
  logic        [99:0] s5_dsq_q;

  // ---------------------------------------------------------------- discriminant
  logic signed [102:0]  disc_s;
  logic                 disc_neg;
  logic [RadW-1:0]      sq1_rad;
  rsnh_pkg::sq1_pay_t   sq1_in, sq1_p;
  logic [$bits(rsnh_pkg::sq1_pay_t)-1:0] sq1_pay_o;
  logic                 sq1_vld;
  logic [RootW-1:0]     sq1_root;

  always_comb begin
    disc_s         = $signed({3'b000, s5_dsq_q}) - (103'(s5_gam_q) <<< 16);
    disc_neg       = disc_s[102];
    sq1_rad        = disc_neg ? '0 : disc_s[RadW-1:0];
    sq1_in.miss    = disc_neg;
    sq1_in.best    = s5_best_q;
    sq1_in.dot     = s5_dot_q;
    for (int i = 0; i < NL; i++) begin
      sq1_in.oc[i] = s5_oc_q[i];
      sq1_in.e[i]  = s5_e_q[i];
      sq1_in.d[i]  = s5_d_q[i];
    end
  end

  rsnh_sqrt #(
    .RadW (RadW),
    .PayW ($bits(rsnh_pkg::sq1_pay_t))
  ) u_sqrt_disc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (s5_vld_q),
    .rad_i  (sq1_rad),
    .pay_i  (sq1_in),
    .vld_o  (sq1_vld),
    .root_o (sq1_root),
    .pay_o  (sq1_pay_o)
  );

  assign sq1_p = rsnh_pkg::sq1_pay_t'(sq1_pay_o);

  // ---------------------------------------------------------------- S7: t = -dot - s
  logic signed [52:0] t_c;
  logic               t_bad;
  logic               s7_vld_q;
  logic signed [31:0] s7_e_q  [NL];
  logic signed [31:0] s7_d_q  [NL];
  logic signed [32:0] s7_oc_q [NL];
  logic        [47:0] s7_best_q;
  logic               s7_miss_q;
  logic        [31:0] s7_t_q;

  always_comb begin
    t_c   = -53'(sq1_p.dot) - $signed({2'b00, sq1_root});
    // Drop roots behind the origin and roots whose square overflows
    t_bad = (t_c[52:32] != '0) || (t_c[31:0] == '0);
  end

  // ---------------------------------------------------------------- S8: t^2, d*t
  logic               s8_vld_q;
  logic signed [31:0] s8_e_q  [NL];
  logic signed [32:0] s8_oc_q [NL];
  logic        [47:0] s8_best_q;
  logic               s8_miss_q;
  logic        [63:0] s8_tsq_q;
  logic signed [64:0] s8_mp_q [NL];

  // ---------------------------------------------------------------- S9: point, v
  logic signed [48:0] m_c  [NL];
  logic signed [49:0] psum [NL];
  logic        [31:0] pt_c [NL];
  logic signed [49:0] v_c  [NL];
  logic        [47:0] t2_c;
  logic               s9_vld_q;
  logic        [47:0] s9_best_q;
  logic               s9_miss_q;
  logic        [47:0] s9_t2_q;
  logic        [31:0] s9_pt_q [NL];
  logic signed [49:0] s9_v_q  [NL];

  always_comb begin
    t2_c = s8_tsq_q[63:16];
    for (int i = 0; i < NL; i++) begin
      m_c[i]  = 49'(s8_mp_q[i] >>> 16);
      psum[i] = 50'(s8_e_q[i]) + 50'(m_c[i]);
      v_c[i]  = 50'(s8_oc_q[i]) + 50'(m_c[i]);
      if (psum[i] > 50'sd2147483647) begin
        pt_c[i] = 32'h7FFF_FFFF;
      end else if (psum[i] < -50'sd2147483648) begin
        pt_c[i] = 32'h8000_0000;
      end else begin
        pt_c[i] = psum[i][31:0];
      end
    end
  end

  // ---------------------------------------------------------------- S10: |v|^2 partials
  logic [VmW-1:0]     vm_c [NL];
  logic               s10_vld_q;
  logic        [47:0] s10_best_q;
  logic               s10_miss_q;
  logic        [47:0] s10_t2_q;
  logic        [31:0] s10_pt_q [NL];
  logic [NL-1:0]      s10_vneg_q;
  logic [VmW-1:0]     s10_vm_q [NL];
  logic        [49:0] s10_hh_q [NL];
  logic        [49:0] s10_hl_q [NL];
  logic        [49:0] s10_ll_q [NL];

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      vm_c[i] = s9_v_q[i][49] ? VmW'(-s9_v_q[i]) : VmW'(s9_v_q[i]);
    end
  end

  // ---------------------------------------------------------------- S11: |v|^2 per lane
  logic               s11_vld_q;
  logic        [47:0] s11_best_q;
  logic               s11_miss_q;
  logic        [47:0] s11_t2_q;
  logic        [31:0] s11_pt_q [NL];
  logic [NL-1:0]      s11_vneg_q;
  logic [VmW-1:0]     s11_vm_q [NL];
  logic        [99:0] s11_vsq_q [NL];

  // ---------------------------------------------------------------- normal length
  logic [RadW-1:0]    acc_c;
  rsnh_pkg::sq2_pay_t sq2_in, sq2_p;
  logic [$bits(rsnh_pkg::sq2_pay_t)-1:0] sq2_pay_o;
  logic               sq2_vld;
  logic [RootW-1:0]   sq2_len;

  always_comb begin
    acc_c       = RadW'(s11_vsq_q[0]) + RadW'(s11_vsq_q[1]) + RadW'(s11_vsq_q[2]);
    sq2_in.miss = s11_miss_q;
    sq2_in.best = s11_best_q;
    sq2_in.t2   = s11_t2_q;
    sq2_in.vneg = s11_vneg_q;
    for (int i = 0; i < NL; i++) begin
      sq2_in.pt[i] = s11_pt_q[i];
      sq2_in.vm[i] = s11_vm_q[i];
    end
  end

  rsnh_sqrt #(
    .RadW (RadW),
    .PayW ($bits(rsnh_pkg::sq2_pay_t))
  ) u_sqrt_len (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (s11_vld_q),
    .rad_i  (acc_c),
    .pay_i  (sq2_in),
    .vld_o  (sq2_vld),
    .root_o (sq2_len),
    .pay_o  (sq2_pay_o)
  );

  assign sq2_p = rsnh_pkg::sq2_pay_t'(sq2_pay_o);

  // ---------------------------------------------------------------- normalize
  logic [VmW-1:0]     dv_mag [NL];
  rsnh_pkg::div_pay_t dv_in, dv_p;
  logic [$bits(rsnh_pkg::div_pay_t)-1:0] dv_pay_o;
  logic               dv_vld;
  logic [QuoW-1:0]    dv_quo [NL];

  always_comb begin
    dv_in.miss = sq2_p.miss;
    dv_in.best = sq2_p.best;
    dv_in.t2   = sq2_p.t2;
    dv_in.vneg = sq2_p.vneg;
    dv_in.lz   = (sq2_len == '0);
    for (int i = 0; i < NL; i++) begin
      dv_in.pt[i] = sq2_p.pt[i];
      dv_mag[i]   = sq2_p.vm[i];
    end
  end

  rsnh_div #(
    .MagW (VmW),
    .DenW (RootW),
    .QuoW (QuoW),
    .PayW ($bits(rsnh_pkg::div_pay_t))
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (sq2_vld),
    .mag_i  (dv_mag),
    .den_i  (sq2_len),
    .pay_i  (dv_in),
    .vld_o  (dv_vld),
    .quo_o  (dv_quo),
    .pay_o  (dv_pay_o)
  );

  assign dv_p = rsnh_pkg::div_pay_t'(dv_pay_o);

  // ---------------------------------------------------------------- output
  logic signed [31:0] nrm [NL];
  rsnh_pkg::out_t     out_d;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      if (dv_p.lz) begin
        nrm[i] = '0;
      end else if (dv_p.vneg[i]) begin
        nrm[i] = -32'(dv_quo[i]);
      end else begin
        nrm[i] = 32'(dv_quo[i]);
      end
    end
    out_d.hit              = !dv_p.miss;
    out_d.new_best_dist_sq = dv_p.miss ? dv_p.best : dv_p.t2;
    out_d.point_x          = dv_p.miss ? '0 : dv_p.pt[0];
    out_d.point_y          = dv_p.miss ? '0 : dv_p.pt[1];
    out_d.point_z          = dv_p.miss ? '0 : dv_p.pt[2];
    out_d.normal_x         = dv_p.miss ? '0 : nrm[0];
    out_d.normal_y         = dv_p.miss ? '0 : nrm[1];
    out_d.normal_z         = dv_p.miss ? '0 : nrm[2];
    out_d.hit_surface      = dv_p.miss ? '0 : surf_q;
  end

  // ---------------------------------------------------------------- stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s7_vld_q  <= 1'b0;
      s8_vld_q  <= 1'b0;
      s9_vld_q  <= 1'b0;
      s10_vld_q <= 1'b0;
      s11_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= in_valid_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      s7_vld_q  <= sq1_vld;
      s8_vld_q  <= s7_vld_q;
      s9_vld_q  <= s8_vld_q;
      s10_vld_q <= s9_vld_q;
      s11_vld_q <= s10_vld_q;
      out_vld_q <= dv_vld;
    end
  end

  // ---------------------------------------------------------------- stage data
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_best_q  <= in_data_i.best_dist_sq;
      s2_best_q  <= s1_best_q;
      s2_r2_q    <= radius_q * radius_q;
      s3_best_q  <= s2_best_q;
      s3_dot_q   <= dot_c;
      s3_gam_q   <= gam_c;
      s4_best_q  <= s3_best_q;
      s4_dot_q   <= s3_dot_q;
      s4_gam_q   <= s3_gam_q;
      s4_hh_q    <= dm[49:25] * dm[49:25];
      s4_hl_q    <= dm[49:25] * dm[24:0];
      s4_ll_q    <= dm[24:0] * dm[24:0];
      s5_best_q  <= s4_best_q;
      s5_dot_q   <= s4_dot_q;
      s5_gam_q   <= s4_gam_q;
      s5_dsq_q   <= (100'(s4_hh_q) << 50) + (100'(s4_hl_q) << 26) + 100'(s4_ll_q);
      s7_best_q  <= sq1_p.best;
      s7_miss_q  <= sq1_p.miss || t_bad;
      s7_t_q     <= t_c[31:0];
      s8_best_q  <= s7_best_q;
      s8_miss_q  <= s7_miss_q;
      s8_tsq_q   <= s7_t_q * s7_t_q;
      s9_best_q  <= s8_best_q;
      s9_miss_q  <= s8_miss_q || (t2_c >= s8_best_q);
      s9_t2_q    <= t2_c;
      s10_best_q <= s9_best_q;
      s10_miss_q <= s9_miss_q;
      s10_t2_q   <= s9_t2_q;
      s11_best_q <= s10_best_q;
      s11_miss_q <= s10_miss_q;
      s11_t2_q   <= s10_t2_q;
      s11_vneg_q <= s10_vneg_q;
      out_q      <= out_d;
      for (int i = 0; i < NL; i++) begin
        s1_e_q[i]     <= e_in[i];
        s1_d_q[i]     <= d_in[i];
        s1_oc_q[i]    <= oc_d[i];
        s2_e_q[i]     <= s1_e_q[i];
        s2_d_q[i]     <= s1_d_q[i];
        s2_oc_q[i]    <= s1_oc_q[i];
        s2_p_q[i]     <= s1_d_q[i] * s1_oc_q[i];
        s2_q_q[i]     <= ocm[i] * ocm[i];
        s3_e_q[i]     <= s2_e_q[i];
        s3_d_q[i]     <= s2_d_q[i];
        s3_oc_q[i]    <= s2_oc_q[i];
        s4_e_q[i]     <= s3_e_q[i];
        s4_d_q[i]     <= s3_d_q[i];
        s4_oc_q[i]    <= s3_oc_q[i];
        s5_e_q[i]     <= s4_e_q[i];
        s5_d_q[i]     <= s4_d_q[i];
        s5_oc_q[i]    <= s4_oc_q[i];
        s7_e_q[i]     <= sq1_p.e[i];
        s7_d_q[i]     <= sq1_p.d[i];
        s7_oc_q[i]    <= sq1_p.oc[i];
        s8_e_q[i]     <= s7_e_q[i];
        s8_oc_q[i]    <= s7_oc_q[i];
        s8_mp_q[i]    <= s7_d_q[i] * $signed({1'b0, s7_t_q});
        s9_pt_q[i]    <= pt_c[i];
        s9_v_q[i]     <= v_c[i];
        s10_pt_q[i]   <= s9_pt_q[i];
        s10_vneg_q[i] <= s9_v_q[i][49];
        s10_vm_q[i]   <= vm_c[i];
        s10_hh_q[i]   <= vm_c[i][49:25] * vm_c[i][49:25];
        s10_hl_q[i]   <= vm_c[i][49:25] * vm_c[i][24:0];
        s10_ll_q[i]   <= vm_c[i][24:0] * vm_c[i][24:0];
        s11_pt_q[i]   <= s10_pt_q[i];
        s11_vm_q[i]   <= s10_vm_q[i];
        s11_vsq_q[i]  <= (100'(s10_hh_q[i]) << 50) + (100'(s10_hl_q[i]) << 26)
                         + 100'(s10_ll_q[i]);
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_miss_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.hit) |->
      (out_data_o.point_x == '0 && out_data_o.point_y == '0 && out_data_o.point_z == '0 &&
       out_data_o.normal_x == '0 && out_data_o.normal_y == '0 &&
       out_data_o.normal_z == '0 && out_data_o.hit_surface == '0))
    else $error("miss result carries hit data");

  a_hit_surface: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.hit) |-> (out_data_o.hit_surface == surf_q))
    else $error("hit surface differs from configured index");

  a_normal_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.normal_x <= 32'sd65536 && out_data_o.normal_x >= -32'sd65536 &&
       out_data_o.normal_y <= 32'sd65536 && out_data_o.normal_y >= -32'sd65536 &&
       out_data_o.normal_z <= 32'sd65536 && out_data_o.normal_z >= -32'sd65536))
    else $error("normal component exceeds unit length");
`endif

endmodule

`default_nettype wire

/* dv/tb_ray_sphere_nearest_hit.sv */
`default_nettype none

module tb_ray_sphere_nearest_hit;

  typedef logic signed [127:0] wide_t;

  localparam logic [rsnh_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
  localparam int                             ONE_Q = 65536;
  localparam int                             CYCLE_LIMIT = 400000;

  typedef struct {
    rsnh_pkg::in_t  ray;
    bit             typed;
    rsnh_pkg::out_t want;
  } row_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_ready_o;
  rsnh_pkg::in_t                   in_data_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  rsnh_pkg::out_t                  out_data_o;
  logic                            cfg_we_i;
  logic [rsnh_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [rsnh_pkg::CFG_DATA_W-1:0] cfg_data_i;

  // sphere as last written
  logic signed [31:0] sph_centre [3];
  logic [30:0]        sph_radius;
  logic [3:0]         sph_surface;

  rsnh_pkg::out_t hit_reports_due [$];
  int   mismatches;
  int   rays_sent;
  int   reports_seen;
  int   cycles;

  ray_sphere_nearest_hit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [63:0] root_floor(wide_t x);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (({64'd0, c} * {64'd0, c}) <= x) r = c;
    end
    return r;
  endfunction

  function automatic rsnh_pkg::out_t trace_sphere(rsnh_pkg::in_t x);
    wide_t e [3];
    wide_t d [3];
    wide_t oc [3];
    wide_t v [3];
    wide_t m, p, dot, sq, gamma, disc, s, t, t2, acc, len, n, mag, lo_sat, hi_sat;
    rsnh_pkg::out_t  r;
    r = '0;
    r.new_best_dist_sq = x.best_dist_sq;
    e[0] = x.origin_x; e[1] = x.origin_y; e[2] = x.origin_z;
    d[0] = x.dir_x;    d[1] = x.dir_y;    d[2] = x.dir_z;
    dot = 0;
    sq  = 0;
    for (int i = 0; i < 3; i++) begin
      oc[i] = e[i] - wide_t'(sph_centre[i]);
      dot  += (d[i] * oc[i]) >>> 16;
      sq   += (oc[i] * oc[i]) >>> 16;
    end
    gamma = sq - ((wide_t'(sph_radius) * wide_t'(sph_radius)) >>> 16);
    disc  = dot * dot - gamma * 65536;
    if (disc < 0) return r;
    s = wide_t'(root_floor(disc));
    t = -dot - s;
    if (t <= 0 || t > wide_t'(64'hFFFF_FFFF)) return r;
    t2 = (t * t) >>> 16;
    if (t2 >= wide_t'(x.best_dist_sq)) return r;
    hi_sat = wide_t'(32'sh7FFF_FFFF);
    lo_sat = -(wide_t'(1) <<< 31);
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      m = (d[i] * t) >>> 16;
      p = e[i] + m;
      if (p > hi_sat) p = hi_sat;
      if (p < lo_sat) p = lo_sat;
      case (i)
        0: r.point_x = p[31:0];
        1: r.point_y = p[31:0];
        default: r.point_z = p[31:0];
      endcase
      v[i] = oc[i] + m;
      acc += v[i] * v[i];
    end
    len = wide_t'(root_floor(acc));
    for (int i = 0; i < 3; i++) begin
      n = 0;
      if (len != 0) begin
        mag = (v[i] < 0) ? -v[i] : v[i];
        n = (mag <<< 16) / len;
        if (v[i] < 0) n = -n;
      end
      case (i)
        0: r.normal_x = n[31:0];
        1: r.normal_y = n[31:0];
        default: r.normal_z = n[31:0];
      endcase
    end
    r.hit = 1'b1;
    r.new_best_dist_sq = t2[47:0];
    r.hit_surface = sph_surface;
    return r;
  endfunction

  function automatic rsnh_pkg::in_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                             logic [47:0] best);
    rsnh_pkg::in_t x;
    x.origin_x = ox; x.origin_y = oy; x.origin_z = oz;
    x.dir_x = dx;    x.dir_y = dy;    x.dir_z = dz;
    x.best_dist_sq = best;
    return x;
  endfunction

  function automatic rsnh_pkg::out_t miss_of(logic [47:0] best);
    rsnh_pkg::out_t r;
    r = '0;
    r.new_best_dist_sq = best;
    return r;
  endfunction

  function automatic int to_raw(real v);
    if (v > 2147483000.0) v = 2147483000.0;
    if (v < -2147483000.0) v = -2147483000.0;
    return $rtoi(v);
  endfunction

  function automatic logic [47:0] draw_best();
    case ($urandom_range(0, 3))
      0: return 48'({$urandom, $urandom});
      1: return 48'($urandom_range(0, 1 << 24));
      default: return '1;
    endcase
  endfunction

  // ray launched from outside toward the sphere, offset within about one radius
  function automatic rsnh_pkg::in_t aimed_ray();
    real dv [3];
    real l, rr, reach, o;
    rsnh_pkg::in_t x;
    int  oraw [3];
    int  draw [3];
    for (int i = 0; i < 3; i++) dv[i] = $urandom_range(0, 2000) - 1000.0;
    l = $sqrt(dv[0] * dv[0] + dv[1] * dv[1] + dv[2] * dv[2]);
    if (l < 1.0) begin
      dv[2] = 1000.0;
      l = 1000.0;
    end
    if ($urandom_range(0, 7) == 0) l = l * ($urandom_range(50, 150) / 100.0);
    rr = sph_radius;
    reach = rr * (1.0 + $urandom_range(0, 400) / 100.0);
    for (int i = 0; i < 3; i++) begin
      o = sph_centre[i] - dv[i] / l * reach
          + ($urandom_range(0, 2000) / 1000.0 - 1.0) * rr * 0.8;
      oraw[i] = to_raw(o);
      draw[i] = to_raw(dv[i] / l * ONE_Q);
    end
    x = make_ray(oraw[0], oraw[1], oraw[2], draw[0], draw[1], draw[2], draw_best());
    return x;
  endfunction

  function automatic rsnh_pkg::in_t noise_ray();
    rsnh_pkg::in_t x;
    x = 240'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom});
    return x;
  endfunction

  // offer one ray; valid stays high across back-to-back transfers
  task automatic send_ray(rsnh_pkg::in_t x, bit typed, rsnh_pkg::out_t want);
    int gap;
    gap = ((rays_sent / 64) % 3 == 1) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= x;
    do @(posedge clk_i); while (!in_ready_o);
    hit_reports_due.push_back(typed ? want : trace_sphere(x));
    rays_sent++;
  endtask

  task automatic set_reg(logic [rsnh_pkg::CFG_IDX_W-1:0] idx,
                         logic [rsnh_pkg::CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      rsnh_pkg::CFG_CENTRE_X:   sph_centre[0] = val;
      rsnh_pkg::CFG_CENTRE_Y:   sph_centre[1] = val;
      rsnh_pkg::CFG_CENTRE_Z:   sph_centre[2] = val;
      rsnh_pkg::CFG_RADIUS:     sph_radius = val[30:0];
      rsnh_pkg::CFG_SURFACE_ID: sph_surface = val[3:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (hit_reports_due.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] exp);
    if (got !== exp) begin
      $display("%0t mismatch %s: expected %h, actual %h", $time, name, exp, got);
      mismatches++;
    end
  endtask

  // receiver: random stalls, plus one long hold-off so the pipeline backs up
  int stall_left;
  int hold_left;
  always @(posedge clk_i or negedge rst_ni) begin
    rsnh_pkg::out_t exp;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (hit_reports_due.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %h", $time, out_data_o);
          mismatches++;
        end else begin
          exp = hit_reports_due.pop_front();
          check_field("hit", 64'(out_data_o.hit), 64'(exp.hit));
          check_field("new_best_dist_sq", 64'(out_data_o.new_best_dist_sq),
                      64'(exp.new_best_dist_sq));
          check_field("point_x", 64'(out_data_o.point_x), 64'(exp.point_x));
          check_field("point_y", 64'(out_data_o.point_y), 64'(exp.point_y));
          check_field("point_z", 64'(out_data_o.point_z), 64'(exp.point_z));
          check_field("normal_x", 64'(out_data_o.normal_x), 64'(exp.normal_x));
          check_field("normal_y", 64'(out_data_o.normal_y), 64'(exp.normal_y));
          check_field("normal_z", 64'(out_data_o.normal_z), 64'(exp.normal_z));
          check_field("hit_surface", 64'(out_data_o.hit_surface), 64'(exp.hit_surface));
        end
        reports_seen++;
        if (reports_seen == 200) hold_left = 400;
        stall_left = ((reports_seen / 64) % 3 == 2) ? 0 : $urandom_range(0, 14);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    row_t rows [$];
    row_t rw;
    rsnh_pkg::out_t want;
    logic [47:0] top;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = rsnh_pkg::CFG_CENTRE_X;
    cfg_data_i   = '0;
    mismatches   = 0;
    rays_sent    = 0;
    reports_seen = 0;
    cycles       = 0;
    sph_centre[0] = 0;
    sph_centre[1] = 0;
    sph_centre[2] = 0;
    sph_radius   = 31'd65536;
    sph_surface  = 4'd0;
    top = '1;

    // unit sphere at origin; ray from z=-5 along +z meets it at t=4
    want = '0;
    want.hit = 1'b1;
    want.new_best_dist_sq = 48'd1048576;
    want.point_z = -32'sd65536;
    want.normal_z = -32'sd65536;
    rw.ray = make_ray(0, 0, -5 * ONE_Q, 0, 0, ONE_Q, top); rw.typed = 1; rw.want = want;
    rows.push_back(rw);
    rw.ray = make_ray(0, 0, -5 * ONE_Q, 0, 0, -ONE_Q, top); rw.typed = 1;
    rw.want = miss_of(top);
    rows.push_back(rw);
    rw.ray = '0; rw.typed = 1; rw.want = miss_of('0);
    rows.push_back(rw);
    rw.ray = make_ray(0, 0, -5 * ONE_Q, 0, 0, ONE_Q, '0); rw.typed = 1;
    rw.want = miss_of('0);
    rows.push_back(rw);
    rw.typed = 0;
    // tangent ray: discriminant exactly zero
    rw.ray = make_ray(ONE_Q, 0, -5 * ONE_Q, 0, 0, ONE_Q, top); rows.push_back(rw);
    rw.ray = make_ray(0, -3 * ONE_Q, 0, 0, ONE_Q, 0, 48'd65536 * 4); rows.push_back(rw);
    rw.ray = make_ray(0, 0, -5 * ONE_Q, 0, 0, 2 * ONE_Q, top); rows.push_back(rw);
    rw.ray = make_ray(0, 0, -5 * ONE_Q, 0, 0, ONE_Q / 4, top); rows.push_back(rw);
    rw.ray = make_ray(ONE_Q / 4, 0, 0, ONE_Q, 0, 0, top); rows.push_back(rw);
    rw.ray = '1; rows.push_back(rw);
    rw.ray = make_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, top);
    rows.push_back(rw);
    rw.ray = make_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000, top);
    rows.push_back(rw);
    rw.ray = make_ray(-20000 * ONE_Q, 0, 0, ONE_Q, 0, 0, top); rows.push_back(rw);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_ray(rows[i].ray, rows[i].typed, rows[i].want);
    for (int k = 0; k < 150; k++) send_ray($urandom_range(0, 3) == 0 ? noise_ray()
                                           : aimed_ray(), 0, '0);

    for (int ph = 1; ph <= 5; ph++) begin
      drain();
      case (ph)
        1: begin
          set_reg(rsnh_pkg::CFG_CENTRE_X, 3 * ONE_Q);
          set_reg(rsnh_pkg::CFG_CENTRE_Y, -2 * ONE_Q);
          set_reg(rsnh_pkg::CFG_CENTRE_Z, 7 * ONE_Q);
          set_reg(rsnh_pkg::CFG_RADIUS, 5 * ONE_Q / 2);
          set_reg(rsnh_pkg::CFG_SURFACE_ID, 5);
          set_reg(CFG_UNUSED_IDX, $urandom);
        end
        2: begin
          set_reg(rsnh_pkg::CFG_CENTRE_X, 32'h7FFF_FFFF);
          set_reg(rsnh_pkg::CFG_CENTRE_Y, 32'h8000_0000);
          set_reg(rsnh_pkg::CFG_CENTRE_Z, 32'h7FFF_FFFF);
          set_reg(rsnh_pkg::CFG_RADIUS, 32'h7FFF_FFFF);
          set_reg(rsnh_pkg::CFG_SURFACE_ID, 15);
        end
        3: begin
          set_reg(rsnh_pkg::CFG_CENTRE_X, -ONE_Q);
          set_reg(rsnh_pkg::CFG_CENTRE_Y, ONE_Q / 2);
          set_reg(rsnh_pkg::CFG_CENTRE_Z, 0);
          set_reg(rsnh_pkg::CFG_RADIUS, 1);
          set_reg(rsnh_pkg::CFG_SURFACE_ID, 9);
        end
        4: begin
          // point sphere
          set_reg(rsnh_pkg::CFG_RADIUS, 0);
          set_reg(rsnh_pkg::CFG_SURFACE_ID, 3);
        end
        default: begin
          set_reg(rsnh_pkg::CFG_CENTRE_X, $urandom_range(0, 2000 * ONE_Q) - 1000 * ONE_Q);
          set_reg(rsnh_pkg::CFG_CENTRE_Y, $urandom_range(0, 2000 * ONE_Q) - 1000 * ONE_Q);
          set_reg(rsnh_pkg::CFG_CENTRE_Z, $urandom_range(0, 2000 * ONE_Q) - 1000 * ONE_Q);
          set_reg(rsnh_pkg::CFG_RADIUS, $urandom_range(ONE_Q / 10, 50 * ONE_Q));
          set_reg(rsnh_pkg::CFG_SURFACE_ID, $urandom_range(0, 15));
        end
      endcase
      cfg_we_i <= 1'b0;
      for (int k = 0; k < 160; k++) send_ray($urandom_range(0, 3) == 0 ? noise_ray()
                                             : aimed_ray(), 0, '0);
    end

    in_valid_i <= 1'b0;
    while (hit_reports_due.size() > 0) @(posedge clk_i);
    repeat (140) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
